@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate-cycle implication, checked on every rising edge out of reset
`define SHA1_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define SHA1_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/sha1_pkg.sv @@
`default_nettype none

package sha1_pkg;

	typedef logic [4:0][31:0] hash_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_COMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic merge;
		logic flush;
		logic clear;
	} pack_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} sched_ctl_t;

	localparam hash_t INIT_CHAIN = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam logic [4:0] WORDS_PER_BLOCK = 5'd16;
	localparam logic [4:0] LEN_WORD_POS = 5'd14;
	localparam logic [6:0] ROUNDS = 7'd80;

endpackage

`default_nettype wire

@@ rtl/sha1_pack.sv @@
`default_nettype none

module sha1_pack (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha1_pkg::pack_ctl_t ctl,
	input  wire logic [31:0]       data_word,
	input  wire logic [2:0]        nbytes,
	output logic                   push,
	output logic [31:0]            push_word,
	output logic [1:0]             off
);
	import sha1_pkg::*;

	logic [31:0] part_q;
	logic [1:0]  off_q;
	logic [31:0] dmask;
	logic [63:0] shifted;
	logic [63:0] joined;
	logic [2:0]  total;

	always_comb begin
		unique case (nbytes)
			3'd0: dmask = 32'h00000000;
			3'd1: dmask = 32'hFF000000;
			3'd2: dmask = 32'hFFFF0000;
			3'd3: dmask = 32'hFFFFFF00;
			default: dmask = 32'hFFFFFFFF;
		endcase
	end

	// new bytes land right after the bytes already held
	assign shifted = {data_word & dmask, 32'h0} >> {off_q, 3'b000};
	assign joined = {part_q, 32'h0} | shifted;
	assign total = {1'b0, off_q} + nbytes;

	assign push = (ctl.merge && total[2]) || ctl.flush;
	assign push_word = ctl.flush ? part_q : joined[63:32];
	assign off = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			off_q <= '0;
		end else if (ctl.clear || ctl.flush) begin
			part_q <= '0;
			off_q <= '0;
		end else if (ctl.merge) begin
			part_q <= total[2] ? joined[31:0] : joined[63:32];
			off_q <= total[1:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/sha1_sched.sv @@
`default_nettype none

module sha1_sched (
	input  wire logic                 clk,
	input  wire sha1_pkg::sched_ctl_t ctl,
	input  wire logic [31:0]          load_word,
	output logic [31:0]               w_out
);
	import sha1_pkg::*;

	logic [31:0] win_q [16];
	logic [31:0] expand;
	logic [31:0] mix;

	// win_q[k] holds w[t+k] during round t
	assign mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign expand = {mix[30:0], mix[31]};
	assign w_out = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= ctl.step ? expand : load_word;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sha1_round.sv @@
`default_nettype none

module sha1_round (
	input  wire sha1_pkg::hash_t vars,
	input  wire logic [31:0]     w,
	input  wire logic [6:0]      rnd,
	output sha1_pkg::hash_t      vars_next
);
	import sha1_pkg::*;

	logic [31:0] a, b, c, d, e;
	logic [31:0] f, k;

	assign a = vars[0];
	assign b = vars[1];
	assign c = vars[2];
	assign d = vars[3];
	assign e = vars[4];

	always_comb begin
		priority if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
			k = K0;
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
			k = K1;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
			k = K2;
		end else begin
			f = b ^ c ^ d;
			k = K3;
		end
	end

	always_comb begin
		vars_next[0] = {a[26:0], a[31:27]} + f + e + k + w;
		vars_next[1] = a;
		vars_next[2] = {b[1:0], b[31:2]};
		vars_next[3] = c;
		vars_next[4] = d;
	end

endmodule

`default_nettype wire

@@ rtl/sha1_hash_engine_top.sv @@
// a word that does not complete a 64-byte block is absorbed straight away while idle
// each completed block takes 80 passes through the shared round unit and one chaining
// update; no new word is accepted while a block is being compressed
// a last word adds a pad step that appends the 0x80 byte, zero fill up to the length position,
// the two length words, the compressions they cause and the digest emit once the output register is free
// reset: asynchronous, chaining value to the initial constants, length and fill to zero
`default_nettype none

module sha1_hash_engine_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_w0,
	output logic [31:0]      digest_w1,
	output logic [31:0]      digest_w2,
	output logic [31:0]      digest_w3,
	output logic [31:0]      digest_w4
);
	import sha1_pkg::*;

	`include "assert_macros.svh"

	state_t      state_q, state_d, after_state, ret_q;
	logic [4:0]  wc_q;
	logic [6:0]  rnd_q;
	logic [60:0] msg_q;
	hash_t       chain_q, vars_q, dig_q, vars_next;
	logic        out_valid_q;

	logic        acc, out_free, emit, finish, len_push, full_push, pad_done;
	logic [2:0]  nsat, pk_n;
	logic [31:0] pk_data, pk_word, len_word, w_cur, sched_word;
	logic        pk_push;
	logic [1:0]  pk_off;
	logic [63:0] bit_len;
	pack_ctl_t   pk_ctl;
	sched_ctl_t  sc_ctl;

	assign nsat = (byte_count > 3'd4) ? 3'd4 : byte_count;
	assign bit_len = {msg_q, 3'b000};
	assign pad_done = (wc_q == LEN_WORD_POS) && (pk_off == 2'd0);

	// control outputs of the sequencer
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		acc = in_valid && (state_q == ST_IDLE);
		out_free = !out_valid_q || !out_stall;
		pk_ctl.merge = acc || (state_q == ST_PAD80);
		pk_ctl.flush = (state_q == ST_PADZ) && !pad_done;
		pk_ctl.clear = (state_q == ST_DONE) && out_free;
		pk_data = (state_q == ST_PAD80) ? PAD_WORD : data_word;
		pk_n = (state_q == ST_PAD80) ? 3'd1 : nsat;
		len_push = (state_q == ST_LEN_HI) || (state_q == ST_LEN_LO);
		len_word = (state_q == ST_LEN_HI) ? bit_len[63:32] : bit_len[31:0];
		sched_word = len_push ? len_word : pk_word;
		sc_ctl.load = pk_push || len_push;
		sc_ctl.step = (state_q == ST_COMP) && (rnd_q < ROUNDS);
		finish = (state_q == ST_COMP) && (rnd_q == ROUNDS);
		emit = (state_q == ST_DONE) && out_free;
		full_push = sc_ctl.load && (wc_q == WORDS_PER_BLOCK - 5'd1);
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:   after_state = (acc && is_last) ? ST_PAD80 : ST_IDLE;
			ST_PAD80:  after_state = ST_PADZ;
			ST_PADZ:   after_state = pad_done ? ST_LEN_HI : ST_PADZ;
			ST_LEN_HI: after_state = ST_LEN_LO;
			ST_LEN_LO: after_state = ST_DONE;
			ST_COMP:   after_state = finish ? ret_q : ST_COMP;
			ST_DONE:   after_state = emit ? ST_IDLE : ST_DONE;
			default:   after_state = ST_IDLE;
		endcase
		// a block that fills up is compressed before going on
		state_d = full_push ? ST_COMP : after_state;
	end

	sha1_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pk_ctl),
		.data_word (pk_data),
		.nbytes    (pk_n),
		.push      (pk_push),
		.push_word (pk_word),
		.off       (pk_off)
	);

	sha1_sched u_sched (
		.clk       (clk),
		.ctl       (sc_ctl),
		.load_word (sched_word),
		.w_out     (w_cur)
	);

	sha1_round u_round (
		.vars      (vars_q),
		.w         (w_cur),
		.rnd       (rnd_q),
		.vars_next (vars_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			wc_q <= '0;
			rnd_q <= '0;
			msg_q <= '0;
			chain_q <= INIT_CHAIN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (full_push) begin
				ret_q <= after_state;
			end
			if (finish) begin
				wc_q <= '0;
			end else if (sc_ctl.load) begin
				wc_q <= wc_q + 5'd1;
			end
			if (full_push) begin
				rnd_q <= '0;
			end else if (sc_ctl.step) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (emit) begin
				msg_q <= '0;
			end else if (acc) begin
				msg_q <= msg_q + {58'd0, nsat};
			end
			if (emit) begin
				chain_q <= INIT_CHAIN;
			end else if (finish) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= chain_q[i] + vars_q[i];
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (full_push) begin
			vars_q <= chain_q;
		end else if (sc_ctl.step) begin
			vars_q <= vars_next;
		end
		if (emit) begin
			dig_q <= chain_q;
		end
	end

	assign out_valid = out_valid_q;
	assign digest_w0 = dig_q[0];
	assign digest_w1 = dig_q[1];
	assign digest_w2 = dig_q[2];
	assign digest_w3 = dig_q[3];
	assign digest_w4 = dig_q[4];

	`SHA1_ASSERT_NEXT(a_full_starts_comp, full_push, (state_q == ST_COMP) && (rnd_q == 7'd0), "full block did not start compression")
	`SHA1_ASSERT_NEXT(a_finish_clears_fill, finish, wc_q == 5'd0, "word count not cleared after compression")
	`SHA1_ASSERT_NOW(a_no_load_in_comp, state_q == ST_COMP, !sc_ctl.load, "schedule loaded during compression")
	`SHA1_ASSERT_NEXT(a_emit_resets, emit, out_valid && (msg_q == 61'd0) && (state_q == ST_IDLE), "digest emit did not reset message state")

endmodule

`default_nettype wire
